@@ rtl/aoc_pkg.sv @@
// Package for the accelerometer offset calibration and Kalman core.
// Holds the transfer structs, config types, controller codes and reset constants.
package aoc_pkg;

  // Config register widths
  localparam int CAL_SAMPLES_W = 11;
  localparam int ONE_G_W       = 12;
  localparam int NOISE_W       = 16;
  localparam int START_COV_W   = 24;

  // Divider geometry: 48-bit dividend, 33-bit divisor, one quotient bit a cycle
  localparam int DIV_W    = 48;
  localparam int DEN_W    = 33;
  localparam int DIV_STEPS = 48;

  // Register reset values
  localparam logic [CAL_SAMPLES_W-1:0] CAL_SAMPLES_RST   = 11'd256;
  localparam logic [ONE_G_W-1:0]       ONE_G_RST         = 12'd256;
  localparam logic [NOISE_W-1:0]       PROCESS_NOISE_RST = 16'd66;
  localparam logic [NOISE_W-1:0]       MEASURE_NOISE_RST = 16'd655;
  localparam logic [START_COV_W-1:0]   START_COV_RST     = 24'd655360;

  // Register map (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_CAL_SAMPLES   = 3'd0,
    REG_ONE_G         = 3'd1,
    REG_PROCESS_NOISE = 3'd2,
    REG_MEASURE_NOISE = 3'd3,
    REG_START_COV     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                     action;
    logic [7:0]               x_low;
    logic [7:0]               x_high;
    logic [7:0]               y_low;
    logic [7:0]               y_high;
    logic [7:0]               z_low;
    logic [7:0]               z_high;
  } sample_t;

  typedef struct packed {
    logic signed [15:0]       corr_x;
    logic signed [15:0]       corr_y;
    logic signed [15:0]       corr_z;
    logic signed [23:0]       filtered_x;
    logic                     cal_done;
    logic                     cal_busy;
  } result_t;

  typedef struct packed {
    logic [CAL_SAMPLES_W-1:0] cal_samples;
    logic [ONE_G_W-1:0]       one_g_counts;
    logic [NOISE_W-1:0]       process_noise;
    logic [NOISE_W-1:0]       measure_noise;
    logic [START_COV_W-1:0]   start_covariance;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CORR, ST_CAL, ST_DIV_START, ST_DIV_WAIT, ST_CAL_END,
    ST_K_START, ST_K_WAIT, ST_MUL_KD, ST_MUL_AA, ST_MUL_KK, ST_MUL_AP,
    ST_MUL_KR, ST_COV, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    AXIS_X, AXIS_Y, AXIS_Z
  } axis_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_CORR, OP_CAL, OP_DIV_START, OP_DIV_WRITE,
    OP_CAL_END, OP_K_START, OP_K_WRITE, OP_K_ZERO, OP_MUL_KD, OP_MUL_AA,
    OP_MUL_KK, OP_MUL_AP, OP_MUL_KR, OP_COV, OP_OUT
  } op_t;

  typedef struct packed {
    op_t   op;
    axis_t axis;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic den_zero;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

@@ rtl/accel_offset_cal_kalman_core.sv @@
// Accelerometer offset calibration with scalar Kalman smoothing on x: top level.
// Depends on aoc_pkg, aoc_regs, aoc_ctrl and aoc_dpath.
//
// One sample is processed at a time. Most of a sample's time goes to the 48-step
// shared serial divider that forms the Kalman gain; the sample that closes a
// calibration run also waits while the same divider forms the three offset averages
// one after another (no gain division when P + R is zero). The next sample is taken
// once the current one's result is in the output register, which may still be waiting
// for a transfer. Registers are written over the APB port at byte address 4 * index;
// the user must write them only while the block is idle, as the block itself does not
// enforce it. Writing start_covariance also reloads the covariance.
module accel_offset_cal_kalman_core #(
  parameter int MAX_CAL_SAMPLES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  aoc_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output aoc_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import aoc_pkg::*;

  cfg_t    cfg;
  logic    cov_load;
  cmd_t    cmd;
  status_t status;

  aoc_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .cov_load (cov_load)
  );

  aoc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  aoc_dpath #(
    .MAX_CAL_SAMPLES (MAX_CAL_SAMPLES)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample       (sample),
    .cfg          (cfg),
    .cov_load     (cov_load),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

@@ rtl/aoc_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on aoc_pkg for the operand widths.
module aoc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [aoc_pkg::DIV_W-1:0] dividend,
  input  logic [aoc_pkg::DEN_W-1:0] divisor,
  output logic                      busy,
  output logic [aoc_pkg::DIV_W-1:0] quotient
);
  import aoc_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [DIV_W-1:0]  dvd;
  logic [STEP_W-1:0] steps;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  // trial remainder with next dividend bit shifted in
  always_comb begin
    trial = {rem, dvd[DIV_W-1]};
    ge    = trial >= {1'b0, den};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= STEP_W'(DIV_STEPS);
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
    end
  end

  // datapath: dividend register doubles as quotient register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= divisor;
      dvd <= dividend;
    end else if (steps != '0) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      dvd <= {dvd[DIV_W-2:0], ge};
    end
  end

  assign busy     = steps != '0;
  assign quotient = dvd;

endmodule

@@ rtl/aoc_regs.sv @@
// APB-style configuration register file.
// Depends on aoc_pkg for the register map and reset values.
module aoc_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output aoc_pkg::cfg_t cfg,
  output logic          cov_load
);
  import aoc_pkg::*;

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cal_samples      <= CAL_SAMPLES_RST;
      cfg.one_g_counts     <= ONE_G_RST;
      cfg.process_noise    <= PROCESS_NOISE_RST;
      cfg.measure_noise    <= MEASURE_NOISE_RST;
      cfg.start_covariance <= START_COV_RST;
    end else if (wr) begin
      case (idx)
        REG_CAL_SAMPLES:   cfg.cal_samples      <= pwdata[CAL_SAMPLES_W-1:0];
        REG_ONE_G:         cfg.one_g_counts     <= pwdata[ONE_G_W-1:0];
        REG_PROCESS_NOISE: cfg.process_noise    <= pwdata[NOISE_W-1:0];
        REG_MEASURE_NOISE: cfg.measure_noise    <= pwdata[NOISE_W-1:0];
        REG_START_COV:     cfg.start_covariance <= pwdata[START_COV_W-1:0];
        default: ;
      endcase
    end
  end

  // covariance reload on a start_covariance write
  always_ff @(posedge clk) begin
    if (rst) begin
      cov_load <= 1'b0;
    end else begin
      cov_load <= wr && (idx == REG_START_COV);
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_CAL_SAMPLES:   prdata = 32'(cfg.cal_samples);
      REG_ONE_G:         prdata = 32'(cfg.one_g_counts);
      REG_PROCESS_NOISE: prdata = 32'(cfg.process_noise);
      REG_MEASURE_NOISE: prdata = 32'(cfg.measure_noise);
      REG_START_COV:     prdata = 32'(cfg.start_covariance);
      default:           prdata = '0;
    endcase
  end

endmodule

@@ rtl/aoc_dpath.sv @@
// Datapath: offset correction, calibration sums and offsets, Kalman state.
// Depends on aoc_pkg and aoc_div; driven by aoc_ctrl through cmd_t.
module aoc_dpath #(
  parameter int MAX_CAL_SAMPLES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  aoc_pkg::cmd_t    cmd,
  output aoc_pkg::status_t status,
  input  aoc_pkg::sample_t sample,
  input  aoc_pkg::cfg_t    cfg,
  input  logic             cov_load,
  output aoc_pkg::result_t result,
  output logic             result_valid,
  input  logic             result_stall
);
  import aoc_pkg::*;

  localparam int CNT_W = $clog2(MAX_CAL_SAMPLES + 1);
  localparam int NW    = (CNT_W > CAL_SAMPLES_W) ? CNT_W : CAL_SAMPLES_W;
  localparam logic [NW-1:0] MAX_N   = NW'(MAX_CAL_SAMPLES);
  localparam logic [16:0]   ONE_Q16 = 17'h10000;

  // captured item
  logic               action;
  logic signed [15:0] raw_x, raw_y, raw_z;
  logic signed [15:0] cx, cy, cz;
  // calibration state
  logic signed [17:0] offset_x, offset_y, offset_z;
  logic signed [31:0] sum_x, sum_y, sum_z;
  logic [CNT_W-1:0]   cal_count;
  logic               cal_done;
  // Kalman state and intermediates
  logic [31:0]        cov;
  logic signed [23:0] est;
  logic [31:0]        p_r;
  logic [DEN_W-1:0]   den_r;
  logic signed [24:0] diff_r;
  logic [16:0]        k_r, a2_r, k2_r;
  logic [32:0]        t1_r;
  logic signed [51:0] prod_r;

  // combinational
  logic [NW-1:0]      n_eff, cs_ext, cnt_ext;
  logic               need_div;
  logic signed [15:0] cx_c, cy_c, cz_c;
  logic [32:0]        pq_c;
  logic [31:0]        p_c;
  logic signed [24:0] diff_c;
  logic signed [31:0] sum_sel;
  logic [31:0]        mag;
  logic               div_start;
  logic [DIV_W-1:0]   div_dvd;
  logic [DEN_W-1:0]   div_den;
  logic               div_busy;
  logic [DIV_W-1:0]   div_q;
  logic [31:0]        q_signed;
  logic [17:0]        off_new;
  logic [16:0]        a_c;
  logic signed [17:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [51:0] mul_p;
  logic signed [51:0] rnd_t;
  logic [35:0]        rnd_p;
  logic signed [35:0] est_q;
  logic signed [36:0] est_sum;
  logic [33:0]        cov_sum;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767)       return 16'sh7FFF;
    else if (v < -19'sd32768) return 16'sh8000;
    else                      return v[15:0];
  endfunction

  function automatic logic signed [18:0] sub_off(input logic signed [15:0] r,
                                                 input logic signed [17:0] o);
    return {{3{r[15]}}, r} - {o[17], o};
  endfunction

  // effective run length, clamped to 1..MAX
  always_comb begin
    cs_ext  = NW'(cfg.cal_samples);
    cnt_ext = NW'(cal_count);
    n_eff   = (cs_ext == '0) ? NW'(1) : cs_ext;
    if (n_eff > MAX_N) n_eff = MAX_N;
    need_div = action && (cal_count != '0) && (cnt_ext >= n_eff);
  end

  // offset correction and covariance predict
  always_comb begin
    cx_c   = sat16(sub_off(raw_x, offset_x));
    cy_c   = sat16(sub_off(raw_y, offset_y));
    cz_c   = sat16(sub_off(raw_z, offset_z));
    pq_c   = {1'b0, cov} + 33'(cfg.process_noise);
    p_c    = pq_c[32] ? 32'hFFFF_FFFF : pq_c[31:0];
    diff_c = {cx[15], cx, 8'b0} - {est[23], est};
  end

  // divider operands
  always_comb begin
    case (cmd.axis)
      AXIS_X:  sum_sel = sum_x;
      AXIS_Y:  sum_sel = sum_y;
      default: sum_sel = sum_z;
    endcase
    mag       = sum_sel[31] ? 32'(-sum_sel) : 32'(sum_sel);
    div_start = (cmd.op == OP_DIV_START) || (cmd.op == OP_K_START);
    if (cmd.op == OP_K_START) begin
      div_dvd = {p_r, 16'b0};
      div_den = den_r;
    end else begin
      div_dvd = DIV_W'(mag);
      div_den = DEN_W'(cal_count);
    end
    q_signed = sum_sel[31] ? (32'd0 - div_q[31:0]) : div_q[31:0];
    off_new  = (cmd.axis == AXIS_Z) ? (q_signed[17:0] - 18'(cfg.one_g_counts))
                                    : q_signed[17:0];
  end

  aoc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_den),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // shared multiplier, 18 x 34 signed
  always_comb begin
    a_c = ONE_Q16 - k_r;
    case (cmd.op)
      OP_MUL_KD: begin mul_a = {1'b0, k_r};  mul_b = 34'(diff_r);          end
      OP_MUL_AA: begin mul_a = {1'b0, a_c};  mul_b = {17'b0, a_c};         end
      OP_MUL_KK: begin mul_a = {1'b0, k_r};  mul_b = {17'b0, k_r};         end
      OP_MUL_AP: begin mul_a = {1'b0, a2_r}; mul_b = {2'b0, p_r};          end
      OP_MUL_KR: begin mul_a = {1'b0, k2_r}; mul_b = 34'(cfg.measure_noise); end
      default:   begin mul_a = '0;           mul_b = '0;                   end
    endcase
    mul_p = mul_a * mul_b;
  end

  // rounding of the previous product, estimate and covariance update
  always_comb begin
    rnd_t   = prod_r + 52'sd32768;
    rnd_p   = rnd_t[51:16];
    est_q   = rnd_t[51:16];
    est_sum = {est_q[35], est_q} + 37'(est);
    cov_sum = 34'(t1_r) + 34'(rnd_p[16:0]);
  end

  assign status.need_div = need_div;
  assign status.den_zero = den_r == '0;
  assign status.div_busy = div_busy;
  assign status.out_free = !result_valid || !result_stall;

  // control-type state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x  <= '0;
      offset_y  <= '0;
      offset_z  <= '0;
      sum_x     <= '0;
      sum_y     <= '0;
      sum_z     <= '0;
      cal_count <= '0;
      cov       <= 32'(START_COV_RST);
      est       <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cov_load) cov <= 32'(cfg.start_covariance);
      if (result_valid && !result_stall) result_valid <= 1'b0;
      case (cmd.op)
        OP_CAL: begin
          if (action) begin
            if (cal_count == '0) begin
              offset_x  <= '0;
              offset_y  <= '0;
              offset_z  <= '0;
              sum_x     <= '0;
              sum_y     <= '0;
              sum_z     <= '0;
              cal_count <= CNT_W'(1);
            end else begin
              sum_x <= sum_x + 32'(cx);
              sum_y <= sum_y + 32'(cy);
              sum_z <= sum_z + 32'(cz);
              if (!need_div) cal_count <= cal_count + 1'b1;
            end
          end
        end
        OP_DIV_WRITE: begin
          case (cmd.axis)
            AXIS_X:  offset_x <= off_new;
            AXIS_Y:  offset_y <= off_new;
            default: offset_z <= off_new;
          endcase
        end
        OP_CAL_END: cal_count <= '0;
        OP_MUL_AA: begin
          if (est_sum > 37'sd8388607)       est <= 24'sh7FFFFF;
          else if (est_sum < -37'sd8388608) est <= 24'sh800000;
          else                              est <= est_sum[23:0];
        end
        OP_COV: cov <= (cov_sum[33:32] != 2'b0) ? 32'hFFFF_FFFF : cov_sum[31:0];
        OP_OUT: result_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        action   <= sample.action;
        raw_x    <= {sample.x_high, sample.x_low};
        raw_y    <= {sample.y_high, sample.y_low};
        raw_z    <= {sample.z_high, sample.z_low};
        cal_done <= 1'b0;
      end
      OP_CORR: begin
        cx  <= cx_c;
        cy  <= cy_c;
        cz  <= cz_c;
        p_r <= p_c;
      end
      OP_CAL: begin
        den_r  <= {1'b0, p_r} + DEN_W'(cfg.measure_noise);
        diff_r <= diff_c;
      end
      OP_CAL_END: cal_done <= 1'b1;
      OP_K_WRITE: k_r <= div_q[16:0];
      OP_K_ZERO:  k_r <= '0;
      OP_MUL_KD:  prod_r <= mul_p;
      OP_MUL_AA:  prod_r <= mul_p;
      OP_MUL_KK: begin
        a2_r   <= rnd_p[16:0];
        prod_r <= mul_p;
      end
      OP_MUL_AP: begin
        k2_r   <= rnd_p[16:0];
        prod_r <= mul_p;
      end
      OP_MUL_KR: begin
        t1_r   <= rnd_p[32:0];
        prod_r <= mul_p;
      end
      OP_OUT: begin
        result.corr_x     <= cx;
        result.corr_y     <= cy;
        result.corr_z     <= cz;
        result.filtered_x <= est;
        result.cal_done   <= cal_done;
        result.cal_busy   <= cal_count != '0;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/aoc_ctrl.sv @@
// Controller state machine sequencing correction, calibration and Kalman steps.
// Depends on aoc_pkg for state, command and status types.
module aoc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  aoc_pkg::status_t status,
  output aoc_pkg::cmd_t    cmd
);
  import aoc_pkg::*;

  state_t state, state_next;
  axis_t  axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= AXIS_X;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    axis_next  = axis;
    case (state)
      ST_IDLE:      if (sample_valid) state_next = ST_CORR;
      ST_CORR:      state_next = ST_CAL;
      ST_CAL: begin
        axis_next  = AXIS_X;
        state_next = status.need_div ? ST_DIV_START : ST_K_START;
      end
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (!status.div_busy) begin
          case (axis)
            AXIS_X:  begin axis_next = AXIS_Y; state_next = ST_DIV_START; end
            AXIS_Y:  begin axis_next = AXIS_Z; state_next = ST_DIV_START; end
            default: state_next = ST_CAL_END;
          endcase
        end
      end
      ST_CAL_END:   state_next = ST_K_START;
      ST_K_START:   state_next = status.den_zero ? ST_MUL_KD : ST_K_WAIT;
      ST_K_WAIT:    if (!status.div_busy) state_next = ST_MUL_KD;
      ST_MUL_KD:    state_next = ST_MUL_AA;
      ST_MUL_AA:    state_next = ST_MUL_KK;
      ST_MUL_KK:    state_next = ST_MUL_AP;
      ST_MUL_AP:    state_next = ST_MUL_KR;
      ST_MUL_KR:    state_next = ST_COV;
      ST_COV:       state_next = ST_OUT;
      ST_OUT:       if (status.out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    sample_stall = state != ST_IDLE;
    cmd.op       = OP_NONE;
    cmd.axis     = axis;
    case (state)
      ST_IDLE:      if (sample_valid) cmd.op = OP_CAPTURE;
      ST_CORR:      cmd.op = OP_CORR;
      ST_CAL:       cmd.op = OP_CAL;
      ST_DIV_START: cmd.op = OP_DIV_START;
      ST_DIV_WAIT:  if (!status.div_busy) cmd.op = OP_DIV_WRITE;
      ST_CAL_END:   cmd.op = OP_CAL_END;
      ST_K_START:   cmd.op = status.den_zero ? OP_K_ZERO : OP_K_START;
      ST_K_WAIT:    if (!status.div_busy) cmd.op = OP_K_WRITE;
      ST_MUL_KD:    cmd.op = OP_MUL_KD;
      ST_MUL_AA:    cmd.op = OP_MUL_AA;
      ST_MUL_KK:    cmd.op = OP_MUL_KK;
      ST_MUL_AP:    cmd.op = OP_MUL_AP;
      ST_MUL_KR:    cmd.op = OP_MUL_KR;
      ST_COV:       cmd.op = OP_COV;
      ST_OUT:       if (status.out_free) cmd.op = OP_OUT;
      default:      cmd.op = OP_NONE;
    endcase
  end

  // one item in flight: a transfer in is followed by a stall
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> sample_stall)
    else $error("item accepted while previous one in flight");

  // divider never restarted mid-operation
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DIV_START || cmd.op == OP_K_START) |-> !status.div_busy)
    else $error("divider started while busy");

  // divider is quiet between items
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !status.div_busy)
    else $error("divider busy in idle");

endmodule

@@ bench/accel_offset_cal_kalman_core_tb.sv @@
// Testbench for accel_offset_cal_kalman_core: offset calibration and Kalman smoothing of x.
// Depends on aoc_pkg and the core RTL; carries its own bit-exact predictor of the result stream.
`timescale 1ns / 100ps

module accel_offset_cal_kalman_core_tb;
  import aoc_pkg::*;

  localparam int  SETTLE_CYCLES = 300;      // covers the slowest (run-closing) sample
  localparam int  CYCLE_LIMIT   = 3000000;
  localparam int  MAX_RUN       = 1024;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  sample_t     sample = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  accel_offset_cal_kalman_core u_dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the block: configuration and calibration/filter state
  cfg_t            shadow_cfg;
  int              off_x, off_y, off_z;
  int              sum_x, sum_y, sum_z;
  int              run_count;
  longint unsigned cov;
  longint          est;

  result_t expected_results[$];
  bit      gaps_on = 1'b0;
  int      mismatches = 0;
  int      samples_sent = 0, results_seen = 0, runs_closed = 0;
  int      cycle_count = 0;
  int      stall_left = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // One Kalman update on the corrected x value
  task automatic kalman_update(longint cx);
    longint unsigned p, den, k, a, a2, k2;
    longint          diff, t, q;
    p = cov + shadow_cfg.process_noise;
    if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
    den = p + shadow_cfg.measure_noise;
    k = (den != 0) ? (p << 16) / den : 0;
    diff = cx * 256 - est;
    t = longint'(k) * diff + 32768;
    q = (t >= 0) ? (t >>> 16) : -((-t + 65535) >>> 16);
    est = clamp(est + q, -8388608, 8388607);
    a  = 65536 - k;
    a2 = (a * a + 32768) >> 16;
    k2 = (k * k + 32768) >> 16;
    p  = ((a2 * p + 32768) >> 16) + ((k2 * shadow_cfg.measure_noise + 32768) >> 16);
    cov = (p > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : p;
  endtask

  // Expected result for one accepted sample
  task automatic predict_result(sample_t s);
    longint  cx, cy, cz;
    int      n;
    result_t r;
    cx = clamp(longint'($signed({s.x_high, s.x_low})) - off_x, -32768, 32767);
    cy = clamp(longint'($signed({s.y_high, s.y_low})) - off_y, -32768, 32767);
    cz = clamp(longint'($signed({s.z_high, s.z_low})) - off_z, -32768, 32767);
    r = '0;
    if (s.action) begin
      if (run_count == 0) begin
        off_x = 0; off_y = 0; off_z = 0;
        sum_x = 0; sum_y = 0; sum_z = 0;
        run_count = 1;
      end else begin
        n = (shadow_cfg.cal_samples == 0) ? 1 : int'(shadow_cfg.cal_samples);
        if (n > MAX_RUN) n = MAX_RUN;
        sum_x += int'(cx); sum_y += int'(cy); sum_z += int'(cz);
        if (run_count >= n) begin
          off_x = sum_x / run_count;
          off_y = sum_y / run_count;
          off_z = sum_z / run_count - int'(shadow_cfg.one_g_counts);
          run_count = 0;
          r.cal_done = 1'b1;
          runs_closed++;
        end else begin
          run_count++;
        end
      end
    end
    kalman_update(cx);
    r.corr_x = cx[15:0];
    r.corr_y = cy[15:0];
    r.corr_z = cz[15:0];
    r.filtered_x = est[23:0];
    r.cal_busy = (run_count != 0);
    expected_results.push_back(r);
  endtask

  // APB write: setup phase, access phase, then back to idle
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CAL_SAMPLES:   shadow_cfg.cal_samples   = value[CAL_SAMPLES_W-1:0];
      REG_ONE_G:         shadow_cfg.one_g_counts  = value[ONE_G_W-1:0];
      REG_PROCESS_NOISE: shadow_cfg.process_noise = value[NOISE_W-1:0];
      REG_MEASURE_NOISE: shadow_cfg.measure_noise = value[NOISE_W-1:0];
      REG_START_COV: begin
        shadow_cfg.start_covariance = value[START_COV_W-1:0];
        cov = value[START_COV_W-1:0];
      end
      default: ;
    endcase
  endtask

  task automatic write_all(int cal, int one_g, int qn, int rn, int p0);
    write_reg(REG_CAL_SAMPLES, cal);
    write_reg(REG_ONE_G, one_g);
    write_reg(REG_PROCESS_NOISE, qn);
    write_reg(REG_MEASURE_NOISE, rn);
    write_reg(REG_START_COV, p0);
  endtask

  // Send one sample; valid stays high unless an idle burst follows
  task automatic send_sample(sample_t s);
    sample <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    predict_result(s);
    samples_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Stop sending and let every outstanding result drain, then let the block settle
  task automatic wait_idle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic sample_t make_sample(int action_pct);
    sample_t s;
    s.action = ($urandom_range(0, 99) < action_pct);
    s.x_low = pick_byte(); s.x_high = pick_byte();
    s.y_low = pick_byte(); s.y_high = pick_byte();
    s.z_low = pick_byte(); s.z_high = pick_byte();
    return s;
  endfunction

  function automatic sample_t fill(bit act, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return '{act, x[7:0], x[15:8], y[7:0], y[15:8], z[7:0], z[15:8]};
  endfunction

  // Receiver idling: random stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Result checker: each transfer against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        want = expected_results.pop_front();
        if (result.corr_x !== want.corr_x || result.corr_y !== want.corr_y ||
            result.corr_z !== want.corr_z || result.filtered_x !== want.filtered_x ||
            result.cal_done !== want.cal_done || result.cal_busy !== want.cal_busy) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d mismatch: exp x=%0d y=%0d z=%0d f=%0d d=%b b=%b",
                     results_seen, want.corr_x, want.corr_y, want.corr_z, want.filtered_x,
                     want.cal_done, want.cal_busy);
            $display("  got x=%0d y=%0d z=%0d f=%0d d=%b b=%b",
                     result.corr_x, result.corr_y, result.corr_z, result.filtered_x,
                     result.cal_done, result.cal_busy);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("accel_offset_cal_kalman_core verification failed");
      $finish;
    end
  end

  // Field extremes at reset settings, then short runs incl. a zero run length
  task automatic test_directed();
    send_sample(fill(0, 16'h0000, 16'hFFFF, 16'h7FFF));
    send_sample(fill(0, 16'h8000, 16'h7FFF, 16'h8000));
    send_sample(fill(0, 16'h7FFF, 16'h8000, 16'hFFFF));
    wait_idle();
    write_reg(REG_CAL_SAMPLES, 0);
    write_reg(REG_ONE_G, 4095);
    send_sample(fill(1, 16'h1234, 16'h5678, 16'h9ABC));   // run opens
    send_sample(fill(1, 16'h7FFF, 16'h8000, 16'h7FFF));   // run closes at once
    send_sample(fill(0, 16'h8000, 16'h7FFF, 16'h8000));   // saturating correction
    send_sample(fill(0, 16'h7FFF, 16'h8000, 16'h7FFF));
    wait_idle();
    write_reg(REG_CAL_SAMPLES, 2);
    write_reg(REG_ONE_G, 0);
    send_sample(fill(1, 16'h0000, 16'h0000, 16'h0000));
    send_sample(fill(1, 16'h8000, 16'h8000, 16'h0100));
    send_sample(fill(1, 16'h8001, 16'hFFFF, 16'h0101));
    send_sample(fill(0, 16'h0000, 16'hFFFF, 16'h0000));
    send_sample(fill(1, 16'h0001, 16'h0002, 16'h0003));   // new run clears offsets
    send_sample(fill(0, 16'h0001, 16'h0002, 16'h0003));
    wait_idle();
  endtask

  // P + R of zero: gain zero, estimate holds; then noise and covariance at their maxima
  task automatic test_zero_denominator();
    write_all(1, 0, 0, 0, 0);
    repeat (4) send_sample(make_sample(30));
    wait_idle();
    write_all(3, 256, 65535, 65535, 16777215);
    repeat (6) send_sample(make_sample(50));
    wait_idle();
  endtask

  // Random phases over varied settings, with a full drain between them
  task automatic test_random_phases(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      case (ph % 4)
        0: write_all($urandom_range(1, 6), $urandom_range(0, 4095), $urandom_range(0, 65535),
                     $urandom_range(1, 65535), $urandom_range(0, 16777215));
        1: write_all($urandom_range(0, 3), 0, 0, 1, 0);
        2: write_all($urandom_range(2, 12), 4095, 65535, 65535, 16777215);
        default: write_all($urandom_range(1, 20), $urandom_range(0, 512), $urandom_range(0, 200),
                           $urandom_range(1, 2000), $urandom_range(0, 2000000));
      endcase
      repeat (per_phase) send_sample(make_sample((ph % 2) ? 80 : 55));
      wait_idle();
    end
  endtask

  // Run length above the maximum acts as the maximum; no idling here
  task automatic test_long_run();
    write_all(2047, $urandom_range(0, 4095), 66, 655, 655360);
    gaps_on = 1'b0;
    for (int i = 0; i < MAX_RUN + 8; i++) send_sample(make_sample((i < MAX_RUN + 1) ? 100 : 0));
    wait_idle();
  endtask

  initial begin
    shadow_cfg = '{CAL_SAMPLES_RST, ONE_G_RST, PROCESS_NOISE_RST, MEASURE_NOISE_RST,
                   START_COV_RST};
    off_x = 0; off_y = 0; off_z = 0;
    sum_x = 0; sum_y = 0; sum_z = 0;
    run_count = 0;
    cov = START_COV_RST;
    est = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gaps_on = 1'b1;
    test_directed();
    test_zero_denominator();
    test_random_phases(10, 40);
    test_long_run();

    $display("%0d samples sent, %0d results checked, %0d calibration runs closed",
             samples_sent, results_seen, runs_closed);
    $display("settings covered run lengths 0 to 2047, noise and covariance extremes");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("accel_offset_cal_kalman_core verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("accel_offset_cal_kalman_core verification failed");
    end
    $finish;
  end

endmodule
